// ===== src/mrcp_pkg.sv =====
package mrcp_pkg;

  // Frame and register limits
  localparam int MAX_FRAME_BYTES = 256;
  localparam int MAX_REGISTERS   = 125;
  localparam int READ_BYTES_MAX  = 2 * MAX_REGISTERS;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 1;

  // Framing modes
  localparam logic MODE_RTU = 1'b0;
  localparam logic MODE_TCP = 1'b1;

  // Result kinds
  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_CRC_BAD     = 4'd2;
  localparam logic [3:0] ST_PID_NONZERO = 4'd3;
  localparam logic [3:0] ST_INCOMPLETE  = 4'd4;
  localparam logic [3:0] ST_EMPTY_PDU   = 4'd5;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd6;
  localparam logic [3:0] ST_COUNT_BIG   = 4'd7;
  localparam logic [3:0] ST_PDU_SHORT   = 4'd8;

  // Function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
  localparam logic [7:0] FC_WRITE_REG    = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS   = 8'd16;
  localparam logic [7:0] FC_EXC_MASK     = 8'h80;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] PID_MODBUS = 16'h0000;

  // Bit positions of the result fields in the output tdata
  localparam int STATUS_LSB = 23;

  typedef struct packed {
    logic        item_kind;
    logic [6:0]  reg_index;
    logic [15:0] reg_value;
    logic [3:0]  status;
    logic [7:0]  unit_id;
    logic [6:0]  fn_code;
    logic        exc_flag;
    logic [7:0]  exc_code;
    logic [15:0] trans_id;
    logic [7:0]  data_count;
    logic [15:0] ack_address;
    logic [15:0] ack_value;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_read_fc(input logic [7:0] fc);
    return (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
  endfunction

  function automatic logic is_write_fc(input logic [7:0] fc);
    return (fc == FC_WRITE_COIL) || (fc == FC_WRITE_REG) ||
           (fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGS);
  endfunction

endpackage

// ===== src/modbus_response_checker_parser_top.sv =====
// Modbus response checker and parser. Response bytes enter on the s_axis side,
// one byte per transaction, tlast on the final byte of the frame. The mode
// register selects RTU framing (CRC-16/MODBUS trailer, low byte first) or TCP
// framing (MBAP header); write it only between frames. The block takes one
// byte per cycle while ready: every byte is parsed combinationally against
// the frame state registers and its results go into a four-entry result queue.
// A byte yields at most two results: a register word for function 3 or 4 (tuser 0),
// and on the tlast byte the frame summary (tuser 1), word first. Register words
// are provisional until the summary status confirms the frame. s_axis_tready
// drops only while fewer than two queue entries are free, so with the master
// side ready a byte is taken in every cycle. In RTU mode register words come
// out two bytes late because the last two bytes of a frame are the trailer.
// Bytes beyond 256 per frame are dropped; tlast still closes the frame.
module modbus_response_checker_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  // framing mode register: 0 RTU, 1 TCP
  input  logic                            mode_wr_en,
  input  logic                            mode_wr_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] rx_byte
  input  logic [mrcp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [6:0] reg_index, [22:7] reg_value, [26:23] status, [34:27] unit id,
  // [41:35] function code, [42] exception flag, [50:43] exception code byte,
  // [66:51] MBAP transaction id, [74:67] read data count, [90:75] ack_address,
  // [106:91] ack_value, [111:107] zero
  output logic [mrcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] item_kind
  output logic [mrcp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  import mrcp_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Frame state
  logic             mode;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      crc_acc, crc_acc_next;
  logic [15:0]      delayed_bytes, delayed_bytes_next;
  logic [15:0]      mbap_tid, mbap_tid_next;
  logic [15:0]      mbap_pid, mbap_pid_next;
  logic [15:0]      mbap_len, mbap_len_next;
  logic [15:0]      unit_and_function, unit_and_function_next;
  logic [7:0]       exception_byte, exception_byte_next;
  logic [7:0]       read_byte_count, read_byte_count_next;
  logic [7:0]       high_byte_hold, high_byte_hold_next;
  logic [31:0]      ack_fields, ack_fields_next;

  // Result queue
  result_t          queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] q_count;

  logic             in_acc, out_acc;
  logic             frame_open;
  logic [7:0]       rx;
  logic             body_vld;
  logic [7:0]       body_b;
  logic [POS_W-1:0] body_pos;
  logic             pdu_vld;
  logic [POS_W-1:0] pdu_q;
  logic [POS_W-1:0] pdu_qm3;
  logic [POS_W-1:0] rbc_ext;
  logic [7:0]       fc;
  logic             word_vld;
  result_t          word_res, sum_res;
  logic [15:0]      trailer;
  logic [3:0]       st;
  logic [7:0]       fc_next;

  // Check the payload against what the function code needs
  function automatic logic [3:0] payload_status(input logic [15:0] avail,
                                                input logic [7:0] f,
                                                input logic [7:0] rbc);
    logic [3:0] s;
    if ((f & FC_EXC_MASK) != 8'h00) begin
      s = (avail < 16'd2) ? ST_PDU_SHORT : ST_OK;
    end else if (is_read_fc(f)) begin
      if ({8'h00, rbc} > 16'(READ_BYTES_MAX)) begin
        s = ST_COUNT_BIG;
      end else begin
        s = ({1'b0, avail} < (17'd2 + {9'h000, rbc})) ? ST_PDU_SHORT : ST_OK;
      end
    end else if (is_write_fc(f)) begin
      s = (avail < 16'd5) ? ST_PDU_SHORT : ST_OK;
    end else begin
      s = ST_UNSUPPORTED;
    end
    return s;
  endfunction

  assign in_acc     = s_axis_tvalid & s_axis_tready;
  assign out_acc    = m_axis_tvalid & m_axis_tready;
  assign frame_open = byte_position < POS_W'(MAX_FRAME_BYTES);
  assign rx         = s_axis_tdata[7:0];
  assign fc         = unit_and_function[7:0];
  assign pdu_qm3    = pdu_q - POS_W'(3);
  assign rbc_ext    = POS_W'(read_byte_count);

  // Parse one byte and build its results
  always_comb begin
    byte_position_next     = byte_position;
    crc_acc_next           = crc_acc;
    delayed_bytes_next     = delayed_bytes;
    mbap_tid_next          = mbap_tid;
    mbap_pid_next          = mbap_pid;
    mbap_len_next          = mbap_len;
    unit_and_function_next = unit_and_function;
    exception_byte_next    = exception_byte;
    read_byte_count_next   = read_byte_count;
    high_byte_hold_next    = high_byte_hold;
    ack_fields_next        = ack_fields;
    body_vld = 1'b0;
    body_b   = rx;
    body_pos = byte_position;
    pdu_vld  = 1'b0;
    pdu_q    = '0;
    word_vld = 1'b0;
    word_res = '0;
    word_res.item_kind = KIND_WORD;

    // Pick the byte to parse: RTU runs two bytes behind to strip the trailer
    if (frame_open) begin
      byte_position_next = byte_position + POS_W'(1);
      if (mode == MODE_RTU) begin
        delayed_bytes_next = {delayed_bytes[7:0], rx};
        if (byte_position >= POS_W'(2)) begin
          body_vld = 1'b1;
          body_b   = delayed_bytes[15:8];
          body_pos = byte_position - POS_W'(2);
        end
      end else begin
        body_vld = 1'b1;
      end
    end

    // Frame header: slave id, MBAP words, CRC
    if (body_vld) begin
      if (mode == MODE_RTU) begin
        crc_acc_next = crc_byte(crc_acc, body_b);
        if (body_pos == '0) begin
          unit_and_function_next[15:8] = body_b;
        end else begin
          pdu_vld = 1'b1;
          pdu_q   = body_pos - POS_W'(1);
        end
      end else if (body_pos < POS_W'(6)) begin
        case (body_pos[2:1])
          2'd0:    mbap_tid_next = {mbap_tid[7:0], body_b};
          2'd1:    mbap_pid_next = {mbap_pid[7:0], body_b};
          default: mbap_len_next = {mbap_len[7:0], body_b};
        endcase
      end else if (body_pos == POS_W'(6)) begin
        unit_and_function_next[15:8] = body_b;
      end else if ((mbap_len >= 16'd2) &&
                   (16'(body_pos - POS_W'(7)) < (mbap_len - 16'd1))) begin
        pdu_vld = 1'b1;
        pdu_q   = body_pos - POS_W'(7);
      end
    end

    // PDU: function code, exception, register data, write echo
    if (pdu_vld) begin
      if (pdu_q == '0) begin
        unit_and_function_next[7:0] = body_b;
      end else if ((fc & FC_EXC_MASK) != 8'h00) begin
        if (pdu_q == POS_W'(1)) begin
          exception_byte_next = body_b;
        end
      end else if (is_read_fc(fc)) begin
        if (pdu_q == POS_W'(1)) begin
          read_byte_count_next = body_b;
        end else if ((read_byte_count <= 8'(READ_BYTES_MAX)) &&
                     (pdu_q <= rbc_ext + POS_W'(1))) begin
          if (!pdu_q[0]) begin
            high_byte_hold_next = body_b;
          end else begin
            word_vld           = 1'b1;
            word_res.reg_index = pdu_qm3[7:1];
            word_res.reg_value = {high_byte_hold, body_b};
          end
        end
      end else if (is_write_fc(fc)) begin
        if (pdu_q <= POS_W'(4)) begin
          ack_fields_next = {ack_fields[23:0], body_b};
        end
      end
    end
  end

  // Frame summary from the state after this byte
  always_comb begin
    sum_res = '0;
    sum_res.item_kind = KIND_SUMMARY;
    fc_next = unit_and_function_next[7:0];
    trailer = frame_open ? {rx, delayed_bytes[7:0]} : {delayed_bytes[7:0], delayed_bytes[15:8]};
    if (mode == MODE_RTU) begin
      if (byte_position_next < POS_W'(5)) begin
        st = ST_SHORT;
      end else if (crc_acc_next != trailer) begin
        st = ST_CRC_BAD;
      end else begin
        st = payload_status(16'(byte_position_next - POS_W'(3)), fc_next,
                            read_byte_count_next);
      end
    end else begin
      if (byte_position_next < POS_W'(8)) begin
        st = ST_SHORT;
      end else if (mbap_pid_next != PID_MODBUS) begin
        st = ST_PID_NONZERO;
      end else if (17'(byte_position_next) < (17'd6 + {1'b0, mbap_len_next})) begin
        st = ST_INCOMPLETE;
      end else if (mbap_len_next < 16'd2) begin
        st = ST_EMPTY_PDU;
      end else begin
        st = payload_status(mbap_len_next - 16'd1, fc_next, read_byte_count_next);
      end
      if (st != ST_SHORT) begin
        sum_res.trans_id = mbap_tid_next;
      end
    end
    sum_res.status = st;
    if ((st == ST_OK) || (st >= ST_EMPTY_PDU)) begin
      sum_res.unit_id  = unit_and_function_next[15:8];
      sum_res.fn_code  = fc_next[6:0];
      sum_res.exc_flag = fc_next[7];
    end
    if (st == ST_OK) begin
      if (fc_next[7]) begin
        sum_res.exc_code = exception_byte_next;
      end else if (is_read_fc(fc_next)) begin
        sum_res.data_count = read_byte_count_next;
      end else if (is_write_fc(fc_next)) begin
        sum_res.ack_address = ack_fields_next[31:16];
        sum_res.ack_value   = ack_fields_next[15:0];
      end
    end
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RTU;
    end else if (mode_wr_en) begin
      mode <= mode_wr_data;
    end
  end

  // Advance frame state; clear it once the tlast byte is taken
  always_ff @(posedge clk) begin
    if (rst || (in_acc && s_axis_tlast)) begin
      byte_position     <= '0;
      crc_acc           <= CRC_INIT;
      delayed_bytes     <= '0;
      mbap_tid          <= '0;
      mbap_pid          <= '0;
      mbap_len          <= '0;
      unit_and_function <= '0;
      exception_byte    <= '0;
      read_byte_count   <= '0;
      high_byte_hold    <= '0;
      ack_fields        <= '0;
    end else if (in_acc) begin
      byte_position     <= byte_position_next;
      crc_acc           <= crc_acc_next;
      delayed_bytes     <= delayed_bytes_next;
      mbap_tid          <= mbap_tid_next;
      mbap_pid          <= mbap_pid_next;
      mbap_len          <= mbap_len_next;
      unit_and_function <= unit_and_function_next;
      exception_byte    <= exception_byte_next;
      read_byte_count   <= read_byte_count_next;
      high_byte_hold    <= high_byte_hold_next;
      ack_fields        <= ack_fields_next;
    end
  end

  // Push up to two results, word first
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (word_vld) begin
        queue[wr_ptr] <= word_res;
      end
      if (s_axis_tlast) begin
        queue[wr_ptr + QPTR_W'(word_vld)] <= sum_res;
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPTR_W'(in_acc & word_vld) + QPTR_W'(in_acc & s_axis_tlast);
      rd_ptr  <= rd_ptr + QPTR_W'(out_acc);
      q_count <= q_count + QCNT_W'(in_acc & word_vld) + QCNT_W'(in_acc & s_axis_tlast)
                 - QCNT_W'(out_acc);
    end
  end

  assign s_axis_tready = q_count <= QCNT_W'(QDEPTH - 2);
  assign m_axis_tvalid = q_count != '0;
  assign m_axis_tuser  = queue[rd_ptr].item_kind;
  assign m_axis_tdata  = {5'b00000,
                          queue[rd_ptr].ack_value,
                          queue[rd_ptr].ack_address,
                          queue[rd_ptr].data_count,
                          queue[rd_ptr].trans_id,
                          queue[rd_ptr].exc_code,
                          queue[rd_ptr].exc_flag,
                          queue[rd_ptr].fn_code,
                          queue[rd_ptr].unit_id,
                          queue[rd_ptr].status,
                          queue[rd_ptr].reg_value,
                          queue[rd_ptr].reg_index};

endmodule

// ===== src/mrcp_checker.sv =====
module mrcp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mrcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [mrcp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  import mrcp_pkg::*;

  // Nothing comes out right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result presented right after reset");

  // A stalled result holds
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Summaries carry no register word
  a_summary_no_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] == KIND_SUMMARY) |-> m_axis_tdata[22:0] == '0)
    else $error("summary carries register word bits");

  // Register words carry nothing but index and value
  a_word_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] == KIND_WORD) |->
      m_axis_tdata[OUT_TDATA_W-1:STATUS_LSB] == '0)
    else $error("register word carries summary bits");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[STATUS_LSB+3:STATUS_LSB] <= ST_PDU_SHORT)
    else $error("undefined status code");

endmodule

bind modbus_response_checker_parser_top mrcp_checker u_mrcp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
